### src/sfd_pkg.sv
package sfd_pkg;

    localparam logic [7:0] DELIM_START = 8'hFE;
    localparam logic [7:0] DELIM_CMD   = 8'hFC;
    localparam logic [7:0] DELIM_FILE  = 8'hFA;

    localparam logic [3:0] ST_HUNT1 = 4'd0;
    localparam logic [3:0] ST_HUNT2 = 4'd1;
    localparam logic [3:0] ST_CCODE = 4'd2;
    localparam logic [3:0] ST_CLEN  = 4'd3;
    localparam logic [3:0] ST_CDATA = 4'd4;
    localparam logic [3:0] ST_FCODE = 4'd5;
    localparam logic [3:0] ST_FLEN  = 4'd6;
    localparam logic [3:0] ST_FDATA = 4'd7;
    localparam logic [3:0] ST_FSUM  = 4'd8;

    localparam logic [2:0] KIND_CMD_BYTE  = 3'd0;
    localparam logic [2:0] KIND_CMD_EMPTY = 3'd1;
    localparam logic [2:0] KIND_FILE_BYTE = 3'd2;
    localparam logic [2:0] KIND_FILE_GOOD = 3'd3;
    localparam logic [2:0] KIND_FILE_BAD  = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  command;
        logic [7:0]  data;
        logic [15:0] index;
        logic [15:0] length;
        logic        last;
    } sfd_result_t;

endpackage

### src/sfd_parser.sv
module sfd_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    input  logic                 rx_overflow,
    output logic                 res_valid,
    output sfd_pkg::sfd_result_t res
);

    logic [3:0]  state_reg, state_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic        len_hi_reg, len_hi_next;
    logic [7:0]  sum_reg, sum_next;
    logic [16:0] count_inc;
    logic        count_done;
    logic [7:0]  sum_add;

    assign count_inc  = {1'b0, count_reg} + 17'd1;
    assign count_done = count_inc >= {1'b0, len_reg};
    assign sum_add    = sum_reg + rx_byte;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        len_hi_next = len_hi_reg;
        sum_next    = sum_reg;
        res_valid   = 1'b0;
        res.kind    = sfd_pkg::KIND_CMD_BYTE;
        res.command = cmd_reg;
        res.data    = 8'd0;
        res.index   = 16'd0;
        res.length  = len_reg;
        res.last    = 1'b0;

        if (rx_overflow)
        begin
            state_next = sfd_pkg::ST_HUNT1;
        end
        else
        begin
            case (state_reg)
                sfd_pkg::ST_HUNT1:
                begin
                    if (rx_byte == sfd_pkg::DELIM_START)
                        state_next = sfd_pkg::ST_HUNT2;
                end
                sfd_pkg::ST_HUNT2:
                begin
                    if (rx_byte == sfd_pkg::DELIM_CMD)
                        state_next = sfd_pkg::ST_CCODE;
                    else if (rx_byte == sfd_pkg::DELIM_FILE)
                    begin
                        sum_next   = sfd_pkg::DELIM_START + sfd_pkg::DELIM_FILE;
                        state_next = sfd_pkg::ST_FCODE;
                    end
                    else
                        state_next = sfd_pkg::ST_HUNT1;
                end
                sfd_pkg::ST_CCODE:
                begin
                    cmd_next   = rx_byte;
                    state_next = sfd_pkg::ST_CLEN;
                end
                sfd_pkg::ST_CLEN:
                begin
                    len_next   = {8'd0, rx_byte};
                    count_next = 16'd0;
                    if (rx_byte == 8'd0)
                    begin
                        state_next = sfd_pkg::ST_HUNT1;
                        res_valid  = 1'b1;
                        res.kind   = sfd_pkg::KIND_CMD_EMPTY;
                        res.length = 16'd0;
                        res.last   = 1'b1;
                    end
                    else
                        state_next = sfd_pkg::ST_CDATA;
                end
                sfd_pkg::ST_CDATA:
                begin
                    count_next = count_inc[15:0];
                    res_valid  = 1'b1;
                    res.kind   = sfd_pkg::KIND_CMD_BYTE;
                    res.data   = rx_byte;
                    res.index  = count_reg;
                    res.last   = count_done;
                    if (count_done)
                        state_next = sfd_pkg::ST_HUNT1;
                end
                sfd_pkg::ST_FCODE:
                begin
                    cmd_next    = rx_byte;
                    sum_next    = sum_add;
                    len_hi_next = 1'b0;
                    len_next    = 16'd0;
                    state_next  = sfd_pkg::ST_FLEN;
                end
                sfd_pkg::ST_FLEN:
                begin
                    sum_next = sum_add;
                    if (!len_hi_reg)
                    begin
                        len_next    = {8'd0, rx_byte};
                        len_hi_next = 1'b1;
                    end
                    else
                    begin
                        // low byte was stored on the previous item
                        len_next    = {rx_byte, len_reg[7:0]};
                        len_hi_next = 1'b0;
                        count_next  = 16'd0;
                        if ({rx_byte, len_reg[7:0]} == 16'd0)
                            state_next = sfd_pkg::ST_FSUM;
                        else
                            state_next = sfd_pkg::ST_FDATA;
                    end
                end
                sfd_pkg::ST_FDATA:
                begin
                    sum_next   = sum_add;
                    count_next = count_inc[15:0];
                    res_valid  = 1'b1;
                    res.kind   = sfd_pkg::KIND_FILE_BYTE;
                    res.data   = rx_byte;
                    res.index  = count_reg;
                    if (count_done)
                        state_next = sfd_pkg::ST_FSUM;
                end
                sfd_pkg::ST_FSUM:
                begin
                    state_next = sfd_pkg::ST_HUNT1;
                    res_valid  = 1'b1;
                    res.kind   = (sum_reg == rx_byte) ? sfd_pkg::KIND_FILE_GOOD
                                                      : sfd_pkg::KIND_FILE_BAD;
                    res.last   = 1'b1;
                end
                default:
                begin
                    state_next = sfd_pkg::ST_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sfd_pkg::ST_HUNT1;
            cmd_reg    <= 8'd0;
            len_reg    <= 16'd0;
            count_reg  <= 16'd0;
            len_hi_reg <= 1'b0;
            sum_reg    <= 8'd0;
        end
        else if (accept)
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            len_hi_reg <= len_hi_next;
            sum_reg    <= sum_next;
        end
    end

endmodule

### src/sfd_out_stage.sv
module sfd_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sfd_pkg::sfd_result_t push_data,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sfd_pkg::sfd_result_t out_data
);

    logic                 main_valid_reg;
    logic                 skid_valid_reg;
    sfd_pkg::sfd_result_t main_reg;
    sfd_pkg::sfd_result_t skid_reg;
    logic                 pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
                main_reg <= push_data;
            else
                skid_reg <= push_data;
        end
    end

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without main entry");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("item pushed into full output stage");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !skid_valid_reg && !push) |=> !main_valid_reg)
        else $error("output stage kept an item that was taken");

endmodule

### src/serial_frame_deframer.sv
// Serial frame deframer: one received byte per item, one item per cycle while
// in_stall is low. Each byte passes through the frame parser in the cycle it is
// accepted; any result lands in a two-entry output register (main plus skid), so
// in_stall is registered and rises only once two results wait unclaimed. Command
// payload and file payload bytes stream out one per item; file frames close with a
// good/bad checksum result. rx_overflow on an accepted item aborts the frame.
module serial_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        rx_overflow,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [7:0]  command_code,
    output logic [7:0]  data_byte,
    output logic [15:0] byte_index,
    output logic [15:0] frame_length,
    output logic        frame_last
);

    logic                 accept;
    logic                 res_valid;
    logic                 full;
    sfd_pkg::sfd_result_t res;
    sfd_pkg::sfd_result_t out_data;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    sfd_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .rx_overflow (rx_overflow),
        .res_valid   (res_valid),
        .res         (res)
    );

    sfd_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign event_kind   = out_data.kind;
    assign command_code = out_data.command;
    assign data_byte    = out_data.data;
    assign byte_index   = out_data.index;
    assign frame_length = out_data.length;
    assign frame_last   = out_data.last;

endmodule
